// ===== rtl/msp_pkg.sv =====
package msp_pkg;

    localparam int BUFFER_DEPTH = 128;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int PTR_W        = $clog2(BUFFER_DEPTH + 1);
    localparam int IDX_W        = 7;
    localparam int CMP_W        = (PTR_W > IDX_W) ? PTR_W : IDX_W;
    localparam int SAT_W        = (PTR_W > 8) ? PTR_W : 8;

    localparam logic [7:0] DOLLAR_BYTE = 8'h24;
    localparam logic [7:0] STAR_BYTE   = 8'h2A;

    typedef enum logic [1:0] {
        FUNC_RX      = 2'd0,
        FUNC_READ    = 2'd1,
        FUNC_RELEASE = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        CFG_SERVO_START = 2'd0,
        CFG_MOTOR_START = 2'd1,
        CFG_END         = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        logic       packet_ready;
        logic [7:0] packet_length;
        logic       in_packet;
        logic       overflow;
        logic       rd_sel;
    } t_status;

endpackage

// ===== rtl/msp_in_if.sv =====
interface msp_in_if import msp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [1:0]       func;
    logic [7:0]       rx_byte;
    logic [IDX_W-1:0] read_index;

    modport source (output valid, output func, output rx_byte, output read_index,
                    input ready);
    modport sink   (input valid, input func, input rx_byte, input read_index,
                    output ready);
endinterface

// ===== rtl/msp_out_if.sv =====
interface msp_out_if import msp_pkg::*; ();
    logic       valid;
    logic       ready;
    logic       packet_ready;
    logic [7:0] packet_length;
    logic [7:0] read_data;
    logic       in_packet;
    logic       overflow;

    modport source (output valid, output packet_ready, output packet_length,
                    output read_data, output in_packet, output overflow,
                    input ready);
    modport sink   (input valid, input packet_ready, input packet_length,
                    input read_data, input in_packet, input overflow,
                    output ready);
endinterface

// ===== rtl/msp_cfg_if.sv =====
interface msp_cfg_if import msp_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/msp_buf.sv =====
module msp_buf import msp_pkg::*; (
    input  logic       i_clk,
    input  t_mem_req   i_req,
    output logic [7:0] o_rd_data
);

    logic [7:0] r_mem [BUFFER_DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // Hold the last read so a stalled result keeps its data
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/msp_ctrl.sv =====
module msp_ctrl import msp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [1:0]       i_func,
    input  logic [7:0]       i_rx_byte,
    input  logic [IDX_W-1:0] i_read_index,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [7:0]       i_cfg_data,
    output t_mem_req         o_req,
    output t_status          o_status
);

    logic [7:0]       r_servo_start;
    logic [7:0]       r_motor_start;
    logic [7:0]       r_end_byte;

    logic             r_collecting;
    logic [PTR_W-1:0] r_wp;
    logic             r_ready;
    logic             r_overflow;

    logic             n_collecting;
    logic [PTR_W-1:0] n_wp;
    logic             n_ready;
    logic             n_overflow;

    logic             start_hit;
    logic             star_hit;
    logic             has_room;
    logic [CMP_W-1:0] idx_ext;
    logic [CMP_W-1:0] wp_ext;
    logic [SAT_W-1:0] wp_sat;
    t_mem_req         req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_servo_start <= '0;
            r_motor_start <= '0;
            r_end_byte    <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SERVO_START: r_servo_start <= i_cfg_data;
                CFG_MOTOR_START: r_motor_start <= i_cfg_data;
                CFG_END:         r_end_byte    <= i_cfg_data;
                default:         ;
            endcase
        end
    end

    assign start_hit = !r_ready && (i_rx_byte == r_servo_start ||
                                    i_rx_byte == r_motor_start ||
                                    i_rx_byte == DOLLAR_BYTE);
    assign star_hit  = !r_ready && (i_rx_byte == STAR_BYTE);
    assign has_room  = (r_wp < PTR_W'(BUFFER_DEPTH));
    assign idx_ext   = CMP_W'(i_read_index);
    assign wp_ext    = CMP_W'(r_wp);

    always_comb begin
        n_collecting = r_collecting;
        n_wp         = r_wp;
        n_ready      = r_ready;
        n_overflow   = r_overflow;
        req          = '0;
        case (t_func'(i_func))
            FUNC_RX: begin
                if (!r_collecting) begin
                    // Either start kind restarts the packet with this byte at slot 0
                    if (start_hit || star_hit) begin
                        n_wp       = PTR_W'(1);
                        n_overflow = 1'b0;
                        req.we     = 1'b1;
                        req.waddr  = '0;
                        req.wdata  = i_rx_byte;
                    end
                    if (start_hit) begin
                        n_collecting = 1'b1;
                    end
                    if (star_hit) begin
                        n_ready = 1'b1;
                    end
                end else begin
                    if (has_room) begin
                        n_wp      = r_wp + PTR_W'(1);
                        req.we    = 1'b1;
                        req.waddr = r_wp[ADDR_W-1:0];
                        req.wdata = i_rx_byte;
                    end else begin
                        n_overflow = 1'b1;
                    end
                    if (i_rx_byte == r_end_byte) begin
                        n_collecting = 1'b0;
                        n_ready      = 1'b1;
                    end
                end
            end
            FUNC_READ: begin
                req.re    = (idx_ext < wp_ext);
                req.raddr = idx_ext[ADDR_W-1:0];
            end
            FUNC_RELEASE: begin
                n_ready = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_collecting <= 1'b0;
            r_wp         <= '0;
            r_ready      <= 1'b0;
            r_overflow   <= 1'b0;
        end else if (i_accept) begin
            r_collecting <= n_collecting;
            r_wp         <= n_wp;
            r_ready      <= n_ready;
            r_overflow   <= n_overflow;
        end
    end

    // Saturate the length at 255; the buffer holds at most 128 bytes
    assign wp_sat = SAT_W'(n_wp);

    always_comb begin
        o_req                  = req;
        o_req.we               = req.we && i_accept;
        o_req.re               = req.re && i_accept;
        o_status.packet_ready  = n_ready;
        o_status.packet_length = (wp_sat > SAT_W'(255)) ? 8'hFF : wp_sat[7:0];
        o_status.in_packet     = n_collecting;
        o_status.overflow      = n_overflow;
        o_status.rd_sel        = req.re;
    end

endmodule

// ===== rtl/multi_start_packet_receiver.sv =====
// Packet receiver for a delimited byte stream. Each beat on i_rx is a command:
// a received byte, a read of a stored byte by index, or a release of the
// waiting packet. While idle with no packet waiting, a byte equal to either
// configured start byte or '$' opens a packet and every later byte is stored
// up to and including the end byte, which raises packet_ready; a lone '*'
// forms a one-byte ready packet at once. Bytes past the buffer depth are
// dropped and set overflow. Every command beat gives exactly one result beat
// showing the status after the command, plus the stored byte for a read (zero
// when out of range). One command is taken per clock while the result
// register is empty or being taken: the control state is registered and the
// packet buffer is a one-port-write, one-port-read memory with a registered
// read that lines up with the result register. The result is available the
// cycle after a command is taken. The user must write start and end bytes
// through i_cfg only while no command is in flight; the block does not enforce it.
module multi_start_packet_receiver import msp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    msp_in_if.sink   i_rx,
    msp_cfg_if.sink  i_cfg,
    msp_out_if.source o_res
);

    logic       accept;
    t_mem_req   req;
    t_status    status;
    logic [7:0] rd_data;

    logic       r_out_valid;
    t_status    r_status;

    assign i_cfg.ready = 1'b1;
    assign i_rx.ready  = !r_out_valid || o_res.ready;
    assign accept      = i_rx.valid && i_rx.ready;

    msp_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_func       (i_rx.func),
        .i_rx_byte    (i_rx.rx_byte),
        .i_read_index (i_rx.read_index),
        .i_cfg_we     (i_cfg.valid),
        .i_cfg_index  (i_cfg.index),
        .i_cfg_data   (i_cfg.data),
        .o_req        (req),
        .o_status     (status)
    );

    msp_buf u_buf (
        .i_clk     (i_clk),
        .i_req     (req),
        .o_rd_data (rd_data)
    );

    // Result register: load on each accepted beat, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= status;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.packet_ready  = r_status.packet_ready;
    assign o_res.packet_length = r_status.packet_length;
    assign o_res.read_data     = r_status.rd_sel ? rd_data : 8'h00;
    assign o_res.in_packet     = r_status.in_packet;
    assign o_res.overflow      = r_status.overflow;

endmodule
